@@ hdl/cds_pkg.sv @@
package cds_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned YOFF_W  = 7;

  localparam logic [KIND_W-1:0] KIND_DAY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MONTH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_YEAR  = 2'd2;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2099;
  localparam logic [YOFF_W-1:0] YOFF_MAX = 7'd99;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               step_down;
    logic               wrap_within;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YOFF_W-1:0]  yoff;
  } norm_t;

  typedef struct packed {
    logic               set_last;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YOFF_W-1:0]  yoff;
  } step_t;

  // The years are offsets from 2000, so only 2000 itself is a century and it is a
  // leap year: the leap rule reduces to the offset being a multiple of four.
  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    return yoff[1:0] == 2'b00;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/cds_if.sv @@
interface cds_req_if;
  logic                         valid;
  logic                         ready;
  logic [cds_pkg::KIND_W-1:0]   kind;
  logic                         step_down;
  logic                         wrap_within;
  logic [cds_pkg::DAY_W-1:0]    day_in;
  logic [cds_pkg::MONTH_W-1:0]  month_in;
  logic [cds_pkg::YEAR_W-1:0]   year_in;

  modport source (output valid, kind, step_down, wrap_within, day_in, month_in, year_in,
                  input ready);
  modport sink (input valid, kind, step_down, wrap_within, day_in, month_in, year_in,
                output ready);
endinterface

interface cds_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cds_pkg::DAY_W-1:0]    day_out;
  logic [cds_pkg::MONTH_W-1:0]  month_out;
  logic [cds_pkg::YEAR_W-1:0]   year_out;

  modport source (output valid, day_out, month_out, year_out, input ready);
  modport sink (input valid, day_out, month_out, year_out, output ready);
endinterface

@@ hdl/cds_norm.sv @@
module cds_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  cds_req_if.sink        req_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cds_pkg::norm_t data_o
);
  import cds_pkg::*;

  logic  valid_q;
  norm_t data_q;
  norm_t data_d;
  logic  load;

  assign req_i.ready = !valid_q || ready_i;
  assign load        = req_i.valid && req_i.ready;

  always_comb begin
    data_d.kind        = req_i.kind;
    data_d.step_down   = req_i.step_down;
    data_d.wrap_within = req_i.wrap_within;
    data_d.day         = (req_i.day_in == '0) ? DAY_FIRST : req_i.day_in;
    if (req_i.month_in < MONTH_JAN) begin
      data_d.month = MONTH_JAN;
    end else if (req_i.month_in > MONTH_DEC) begin
      data_d.month = MONTH_DEC;
    end else begin
      data_d.month = req_i.month_in;
    end
    if (req_i.year_in < YEAR_MIN) begin
      data_d.yoff = '0;
    end else if (req_i.year_in > YEAR_MAX) begin
      data_d.yoff = YOFF_MAX;
    end else begin
      data_d.yoff = YOFF_W'(req_i.year_in - YEAR_MIN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ hdl/cds_step.sv @@
module cds_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cds_pkg::norm_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cds_pkg::step_t data_o
);
  import cds_pkg::*;

  logic             valid_q;
  step_t            data_q;
  step_t            data_d;
  logic [DAY_W-1:0] len;
  logic [DAY_W-1:0] day;

  assign ready_o = !valid_q || ready_i;

  assign len = month_len(data_i.month, is_leap(data_i.yoff));
  assign day = (data_i.day > len) ? len : data_i.day;

  always_comb begin
    data_d.set_last = 1'b0;
    data_d.day      = day;
    data_d.month    = data_i.month;
    data_d.yoff     = data_i.yoff;
    case (data_i.kind)
      KIND_DAY: begin
        if (data_i.step_down) begin
          if (day == DAY_FIRST) begin
            if (!data_i.wrap_within) begin
              data_d.month = (data_i.month == MONTH_JAN) ? MONTH_DEC : data_i.month - 1'b1;
            end
            data_d.set_last = 1'b1;
          end else begin
            data_d.day = day - 1'b1;
          end
        end else begin
          if (day >= len) begin
            if (!data_i.wrap_within) begin
              data_d.month = (data_i.month == MONTH_DEC) ? MONTH_JAN : data_i.month + 1'b1;
            end
            data_d.day = DAY_FIRST;
          end else begin
            data_d.day = day + 1'b1;
          end
        end
      end
      KIND_MONTH: begin
        if (data_i.step_down) begin
          if (data_i.month == MONTH_JAN) begin
            data_d.month = MONTH_DEC;
            if (!data_i.wrap_within && data_i.yoff != '0) begin
              data_d.yoff = data_i.yoff - 1'b1;
            end
          end else begin
            data_d.month = data_i.month - 1'b1;
          end
        end else begin
          if (data_i.month == MONTH_DEC) begin
            data_d.month = MONTH_JAN;
            if (!data_i.wrap_within && data_i.yoff != YOFF_MAX) begin
              data_d.yoff = data_i.yoff + 1'b1;
            end
          end else begin
            data_d.month = data_i.month + 1'b1;
          end
        end
      end
      KIND_YEAR: begin
        if (data_i.step_down) begin
          if (data_i.yoff != '0) begin
            data_d.yoff = data_i.yoff - 1'b1;
          end
        end else if (data_i.yoff != YOFF_MAX) begin
          data_d.yoff = data_i.yoff + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ hdl/cds_clamp.sv @@
module cds_clamp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cds_pkg::step_t data_i,
  cds_rsp_if.source      rsp_o
);
  import cds_pkg::*;

  logic               valid_q;
  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [YEAR_W-1:0]  year_q;
  logic [DAY_W-1:0]   len;
  logic [DAY_W-1:0]   day_d;

  assign ready_o = !valid_q || rsp_o.ready;

  assign len   = month_len(data_i.month, is_leap(data_i.yoff));
  assign day_d = (data_i.set_last || data_i.day > len) ? len : data_i.day;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      day_q   <= day_d;
      month_q <= data_i.month;
      year_q  <= YEAR_MIN + YEAR_W'(data_i.yoff);
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.day_out   = day_q;
  assign rsp_o.month_out = month_q;
  assign rsp_o.year_out  = year_q;
endmodule

@@ hdl/calendar_date_stepper.sv @@
// A result passes the normalise, step and clamp registers in that order before it is
// valid. Throughput: one item per cycle while the response is taken, through three
// register stages (normalise the date, step it, clamp the day to the month length);
// each stage holds while it is full and the next stage cannot take its item.
// Reset clears the valid bit of every stage; the date registers are not reset.
module calendar_date_stepper (
  input  logic      clk_i,
  input  logic      rst_ni,
  cds_req_if.sink   req_i,
  cds_rsp_if.source rsp_o
);
  import cds_pkg::*;

  logic  norm_valid;
  logic  norm_ready;
  norm_t norm_data;
  logic  step_valid;
  logic  step_ready;
  step_t step_data;

  cds_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (norm_valid),
    .ready_i (norm_ready),
    .data_o  (norm_data)
  );

  cds_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .ready_o (norm_ready),
    .data_i  (norm_data),
    .valid_o (step_valid),
    .ready_i (step_ready),
    .data_o  (step_data)
  );

  cds_clamp u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (step_valid),
    .ready_o (step_ready),
    .data_i  (step_data),
    .rsp_o   (rsp_o)
  );

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_valid |-> (norm_data.month >= MONTH_JAN && norm_data.month <= MONTH_DEC &&
                    norm_data.day != '0 && norm_data.yoff <= YOFF_MAX))
    else $error("Normalised date out of range.");

  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid && !step_ready |=> step_valid && $stable(step_data))
    else $error("Stepped item changed while stalled.");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.month_out >= MONTH_JAN && rsp_o.month_out <= MONTH_DEC &&
                     rsp_o.day_out != '0 && rsp_o.year_out >= YEAR_MIN &&
                     rsp_o.year_out <= YEAR_MAX))
    else $error("Result date out of range.");
endmodule
